[sv/hkrb_pkg.sv]
// ----------------------------------------------------------------------------
// hkrb_pkg
// Shared constants and types for the boot-keyboard report builder.
// ----------------------------------------------------------------------------
package hkrb_pkg;

    // Number of key slots kept in the report state
    localparam int SLOT_COUNT = 6;
    // Number of key slots carried in an emitted report
    localparam int OUT_SLOTS  = 6;
    localparam int SLOT_IW    = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;

    localparam int CODE_W  = 8;
    localparam int LIMIT_W = 9;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 9'd232;

    // Modifier usages 0xE0..0xE7 share this upper bit pattern
    localparam logic [4:0] MOD_PREFIX = 5'b11100;

    typedef logic [CODE_W-1:0] t_code;

    typedef enum logic [1:0] {
        REQ_KEY   = 2'd0,
        REQ_TICK  = 2'd1,
        REQ_OTHER = 2'd2,
        REQ_RSVD  = 2'd3
    } t_req;

    // Result of one slot compare
    typedef struct packed {
        logic hit;
        logic empty;
    } t_match;

endpackage

[sv/hkrb_req_if.sv]
// ----------------------------------------------------------------------------
// hkrb_req_if
// Request channel: key events and timer ticks with valid/ready handshake.
// ----------------------------------------------------------------------------
interface hkrb_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] req_type;
    logic [7:0] scancode;
    logic       pressed;
    logic       host_ready;

    modport source (output valid, req_type, scancode, pressed, host_ready, input ready);
    modport sink   (input valid, req_type, scancode, pressed, host_ready, output ready);
endinterface

[sv/hkrb_rpt_if.sv]
// ----------------------------------------------------------------------------
// hkrb_rpt_if
// Report channel: modifier mask and six key slots with valid/ready handshake.
// ----------------------------------------------------------------------------
interface hkrb_rpt_if;
    logic       valid;
    logic       ready;
    logic [7:0] modifier_bits;
    logic [7:0] key_slot_0;
    logic [7:0] key_slot_1;
    logic [7:0] key_slot_2;
    logic [7:0] key_slot_3;
    logic [7:0] key_slot_4;
    logic [7:0] key_slot_5;

    modport source (output valid, modifier_bits, key_slot_0, key_slot_1, key_slot_2,
                    key_slot_3, key_slot_4, key_slot_5, input ready);
    modport sink   (input valid, modifier_bits, key_slot_0, key_slot_1, key_slot_2,
                    key_slot_3, key_slot_4, key_slot_5, output ready);
endinterface

[sv/hkrb_match_unit.sv]
// ----------------------------------------------------------------------------
// hkrb_match_unit
// Shared slot comparator: checks one slot against the key code and for empty.
// ----------------------------------------------------------------------------
module hkrb_match_unit (
    input  hkrb_pkg::t_code  i_slot,
    input  hkrb_pkg::t_code  i_code,
    output hkrb_pkg::t_match o_match
);
    import hkrb_pkg::*;

    // equality and empty test on the selected slot
    always_comb begin
        o_match.hit   = (i_slot == i_code);
        o_match.empty = (i_slot == '0);
    end

endmodule

[sv/hid_keyboard_report_builder_unit.sv]
// ----------------------------------------------------------------------------
// hid_keyboard_report_builder_unit
// Keeps a six-key boot-keyboard report and emits it on key events and ticks.
// ----------------------------------------------------------------------------
// Sequence: a handled key event is accepted in S_IDLE, scanned slot by slot
//   through the shared slot comparator in S_SCAN, and, when host_ready is set,
//   loaded into the report register in S_EMIT, which waits while the output is
//   still held. Ticks and ignored items skip S_SCAN. Not ready while an item is in progress.
// Reset: synchronous, active low; clears slots, modifier mask, pending flag,
//   output valid, and sets the code limit to 232.
// ----------------------------------------------------------------------------
module hid_keyboard_report_builder_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [hkrb_pkg::LIMIT_W-1:0] i_cfg_wdata,
    hkrb_req_if.sink                     i_req,
    hkrb_rpt_if.source                   o_rpt
);
    import hkrb_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EMIT
    } t_state;

    t_state               r_state;
    logic [LIMIT_W-1:0]   r_limit;
    t_code                r_slots [SLOT_COUNT];
    logic [7:0]           r_mod;
    logic                 r_pending;

    // latched item
    t_code                r_code;
    logic                 r_press;
    logic                 r_host_ready;

    // scan bookkeeping
    logic [SLOT_IW-1:0]   r_idx;
    logic                 r_emp_found;
    logic [SLOT_IW-1:0]   r_emp_idx;

    // output register
    logic                 r_out_valid;
    logic [7:0]           r_out_mod;
    t_code                r_out_slot [OUT_SLOTS];

    t_match               w_match;
    logic                 w_accept;
    logic                 w_handled_key;
    logic                 w_is_mod;
    logic [7:0]           w_mod_bit;
    logic                 w_last;
    logic                 w_out_free;

    // shared comparator on the slot under the scan index
    hkrb_match_unit u_match (
        .i_slot  (r_slots[r_idx]),
        .i_code  (r_code),
        .o_match (w_match)
    );

    assign i_req.ready   = (r_state == S_IDLE);
    assign w_accept      = i_req.valid && i_req.ready;
    assign w_handled_key = (t_req'(i_req.req_type) == REQ_KEY)
                           && ({1'b0, i_req.scancode} < r_limit);
    assign w_is_mod      = (i_req.scancode[7:3] == MOD_PREFIX);
    assign w_mod_bit     = 8'(1) << i_req.scancode[2:0];
    assign w_last        = (r_idx == SLOT_IW'(SLOT_COUNT - 1));
    assign w_out_free    = !r_out_valid || o_rpt.ready;

    // sequencer, report state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_limit     <= LIMIT_RESET;
            r_mod       <= '0;
            r_pending   <= 1'b0;
            r_out_valid <= 1'b0;
            r_idx       <= '0;
            r_emp_found <= 1'b0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                r_slots[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                r_limit <= i_cfg_wdata;
            end

            // report taken by the host side; S_EMIT reloads it instead
            if (r_out_valid && o_rpt.ready && r_state != S_EMIT) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_code       <= i_req.scancode;
                        r_press      <= i_req.pressed;
                        r_host_ready <= i_req.host_ready;
                        r_idx        <= '0;
                        r_emp_found  <= 1'b0;
                        if (w_handled_key) begin
                            // modifier bit does not depend on the slots
                            if (w_is_mod) begin
                                if (i_req.pressed) r_mod <= r_mod | w_mod_bit;
                                else               r_mod <= r_mod & ~w_mod_bit;
                            end
                            r_state <= S_SCAN;
                        end else if (t_req'(i_req.req_type) == REQ_TICK
                                     && i_req.host_ready && r_pending) begin
                            r_state <= S_EMIT;
                        end
                    end
                end

                S_SCAN: begin
                    // one slot per cycle; stop on first match
                    if (w_match.hit || w_last) begin
                        if (w_match.hit) begin
                            if (!r_press) r_slots[r_idx] <= '0;
                        end else if (r_press) begin
                            if (r_emp_found)        r_slots[r_emp_idx] <= r_code;
                            else if (w_match.empty) r_slots[r_idx]     <= r_code;
                        end
                        if (r_host_ready) begin
                            r_state <= S_EMIT;
                        end else begin
                            r_pending <= 1'b1;
                            r_state   <= S_IDLE;
                        end
                    end else begin
                        if (w_match.empty && !r_emp_found) begin
                            r_emp_found <= 1'b1;
                            r_emp_idx   <= r_idx;
                        end
                        r_idx <= r_idx + SLOT_IW'(1);
                    end
                end

                S_EMIT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_pending   <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end

                default: r_state <= S_IDLE;
            endcase
        end
    end

    // report snapshot, no reset needed
    always_ff @(posedge i_clk) begin
        if (r_state == S_EMIT && w_out_free) begin
            r_out_mod <= r_mod;
            for (int j = 0; j < OUT_SLOTS; j++) begin
                if (j < SLOT_COUNT) r_out_slot[j] <= r_slots[j];
                else                r_out_slot[j] <= '0;
            end
        end
    end

    // output channel
    assign o_rpt.valid         = r_out_valid;
    assign o_rpt.modifier_bits = r_out_mod;
    assign o_rpt.key_slot_0    = r_out_slot[0];
    assign o_rpt.key_slot_1    = r_out_slot[1];
    assign o_rpt.key_slot_2    = r_out_slot[2];
    assign o_rpt.key_slot_3    = r_out_slot[3];
    assign o_rpt.key_slot_4    = r_out_slot[4];
    assign o_rpt.key_slot_5    = r_out_slot[5];

endmodule

[tb/sv/tb_hkrb_report_sb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hkrb_report_sb_pkg
// Report predictor and scoreboard for the boot-keyboard report builder.
// Mirrors the six slots, the modifier mask and the pending flag, and queues
// the report that each accepted request should produce.
// ----------------------------------------------------------------------------
package tb_hkrb_report_sb_pkg;
    import hkrb_pkg::*;

    typedef struct {
        t_code mods;
        t_code keys [OUT_SLOTS];
    } kb_report_t;

    class kb_report_scoreboard;
        t_code              slot_q [SLOT_COUNT];
        t_code              mod_mask;
        bit                 send_pending;
        logic [LIMIT_W-1:0] code_limit;
        kb_report_t         reports_due [$];
        int                 mismatches;
        int                 reports_seen;
        int                 key_events;
        int                 ticks;
        int                 ignored;

        function void reset_state();
            foreach (slot_q[i]) slot_q[i] = '0;
            mod_mask     = '0;
            send_pending = 1'b0;
            code_limit   = LIMIT_RESET;
        endfunction

        function void set_limit(logic [LIMIT_W-1:0] value);
            code_limit = value;
        endfunction

        function int outstanding();
            return reports_due.size();
        endfunction

        // Snapshot of the current report state
        function void queue_report();
            kb_report_t snap;
            snap.mods = mod_mask;
            for (int j = 0; j < OUT_SLOTS; j++) begin
                snap.keys[j] = (j < SLOT_COUNT) ? slot_q[j] : '0;
            end
            reports_due.push_back(snap);
        endfunction

        // Apply one accepted request; returns 1 unless the block ignores it
        function bit note_item(t_req req, t_code code, bit pressed, bit host_ready);
            int    hit_at;
            int    free_at;
            bit    is_mod;
            t_code mod_bit;
            hit_at  = -1;
            free_at = -1;
            if (req == REQ_KEY && {1'b0, code} < code_limit) begin
                key_events++;
                // first matching slot and first empty slot
                for (int i = 0; i < SLOT_COUNT; i++) begin
                    if (hit_at < 0 && slot_q[i] == code) hit_at = i;
                    if (free_at < 0 && slot_q[i] == '0) free_at = i;
                end
                is_mod  = (code[7:3] == MOD_PREFIX);
                mod_bit = t_code'(1) << code[2:0];
                if (pressed) begin
                    if (hit_at < 0 && free_at >= 0) slot_q[free_at] = code;
                    if (is_mod) mod_mask = mod_mask | mod_bit;
                end else begin
                    if (hit_at >= 0) slot_q[hit_at] = '0;
                    if (is_mod) mod_mask = mod_mask & ~mod_bit;
                end
                if (host_ready) begin
                    queue_report();
                    send_pending = 1'b0;
                end else begin
                    send_pending = 1'b1;
                end
                return 1'b1;
            end
            if (req == REQ_TICK) begin
                ticks++;
                if (host_ready && send_pending) begin
                    queue_report();
                    send_pending = 1'b0;
                end
                return 1'b1;
            end
            ignored++;
            return 1'b0;
        endfunction

        task report_mismatch(string what);
            mismatches++;
            $display("[%0t] report mismatch: %s", $time, what);
        endtask

        // Compare one delivered report with the oldest expected one
        task check_report(kb_report_t got);
            kb_report_t want;
            reports_seen++;
            if (reports_due.size() == 0) begin
                report_mismatch($sformatf("unexpected report mods=%02h keys=%02h %02h %02h %02h %02h %02h",
                    got.mods, got.keys[0], got.keys[1], got.keys[2],
                    got.keys[3], got.keys[4], got.keys[5]));
            end else begin
                want = reports_due.pop_front();
                if (got.mods !== want.mods) begin
                    report_mismatch($sformatf("modifier_bits got %02h want %02h",
                        got.mods, want.mods));
                end
                for (int j = 0; j < OUT_SLOTS; j++) begin
                    if (got.keys[j] !== want.keys[j]) begin
                        report_mismatch($sformatf("key_slot_%0d got %02h want %02h",
                            j, got.keys[j], want.keys[j]));
                    end
                end
            end
        endtask
    endclass

endpackage

[tb/sv/tb_hid_keyboard_report_builder_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_hid_keyboard_report_builder_unit
// Self-checking bench for the boot-keyboard report builder. A directed run
// covers slot/modifier corner cases, then random keyboard traffic runs under
// several code limits with sender gaps, receiver stalls and a long back-off.
// ----------------------------------------------------------------------------
module tb_hid_keyboard_report_builder_unit;
    import hkrb_pkg::*;
    import tb_hkrb_report_sb_pkg::*;

    // Longest busy time of the block plus margin
    localparam int DRAIN_CYCLES = SLOT_COUNT + 6;
    localparam int HOLD_CYCLES  = 300;

    logic               i_clk;
    logic               i_rst_n;
    logic               cfg_we;
    logic [LIMIT_W-1:0] cfg_wdata;

    int send_idle_pct;
    int recv_stall_pct;
    int hold_ask;
    int hold_left;
    int limits_used;

    kb_report_scoreboard sb = new();

    hkrb_req_if req_ch ();
    hkrb_rpt_if rpt_ch ();

    hid_keyboard_report_builder_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_wdata(cfg_wdata),
        .i_req      (req_ch),
        .o_rpt      (rpt_ch)
    );

    // 4 ns clock
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    // Report sink: check accepted reports, then pick next ready
    always @(posedge i_clk) begin : report_sink
        kb_report_t seen;
        if (i_rst_n === 1'b1 && rpt_ch.valid === 1'b1 && rpt_ch.ready === 1'b1) begin
            seen.mods    = rpt_ch.modifier_bits;
            seen.keys[0] = rpt_ch.key_slot_0;
            seen.keys[1] = rpt_ch.key_slot_1;
            seen.keys[2] = rpt_ch.key_slot_2;
            seen.keys[3] = rpt_ch.key_slot_3;
            seen.keys[4] = rpt_ch.key_slot_4;
            seen.keys[5] = rpt_ch.key_slot_5;
            sb.check_report(seen);
        end
        // long back-off counted here, random stalls otherwise
        if (hold_left > 0) begin
            rpt_ch.ready <= 1'b0;
            hold_left--;
        end else if (hold_ask > 0) begin
            rpt_ch.ready <= 1'b0;
            hold_left = hold_ask - 1;
            hold_ask  = 0;
        end else begin
            rpt_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Offer one request and wait until it is taken
    task automatic send_item(input t_req rq, input t_code code, input bit pressed,
                             input bit host_ready, output bit counted);
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        req_ch.valid      <= 1'b1;
        req_ch.req_type   <= rq;
        req_ch.scancode   <= code;
        req_ch.pressed    <= pressed;
        req_ch.host_ready <= host_ready;
        @(posedge i_clk);
        while (req_ch.ready !== 1'b1) @(posedge i_clk);
        counted = sb.note_item(rq, code, pressed, host_ready);
    endtask

    task automatic key(input t_req rq, input t_code code, input bit pressed,
                       input bit host_ready);
        bit counted;
        send_item(rq, code, pressed, host_ready, counted);
    endtask

    // Drop valid and wait until the block has gone quiet
    task automatic settle();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (sb.outstanding() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_limit(input logic [LIMIT_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge i_clk);
        sb.set_limit(value);
        cfg_we <= 1'b0;
        limits_used++;
    endtask

    // Keyboard-like traffic: a small key pool so slots fill and repeat,
    // modifiers, ticks, plus some random codes and ignored requests
    task automatic send_random_request(output bit counted);
        int    r;
        t_req  rq;
        t_code code;
        r = $urandom_range(99);
        if (r < 60)      rq = REQ_KEY;
        else if (r < 85) rq = REQ_TICK;
        else if (r < 93) rq = REQ_OTHER;
        else             rq = REQ_RSVD;
        r = $urandom_range(99);
        if (r < 40)      code = 8'h04 + t_code'($urandom_range(7));
        else if (r < 60) code = 8'hE0 + t_code'($urandom_range(7));
        else if (r < 68) code = 8'h00;
        else             code = t_code'($urandom_range(255));
        send_item(rq, code, $urandom_range(1), $urandom_range(99) < 70, counted);
    endtask

    // count is the number of items offered in the phase, ignored ones included
    task automatic run_phase(input int limit_value, input int idle_pct, input int stall_pct,
                             input int count, input int hold);
        int handled;
        bit counted;
        handled = 0;
        settle();
        write_limit(limit_value[LIMIT_W-1:0]);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        if (hold > 0) hold_ask = hold;
        while (handled < count) begin
            send_random_request(counted);
            handled++;
        end
    endtask

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

    initial begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_ask       = 0;
        hold_left      = 0;
        limits_used    = 1;
        sb.reset_state();
        i_rst_n           <= 1'b0;
        cfg_we            <= 1'b0;
        cfg_wdata         <= '0;
        req_ch.valid      <= 1'b0;
        req_ch.req_type   <= REQ_OTHER;
        req_ch.scancode   <= '0;
        req_ch.pressed    <= 1'b0;
        req_ch.host_ready <= 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: pending flag, zero code, duplicates, full slots, modifiers
        key(REQ_TICK, 8'h00, 1'b0, 1'b1);
        key(REQ_KEY,  8'h04, 1'b1, 1'b0);
        key(REQ_TICK, 8'h00, 1'b0, 1'b0);
        key(REQ_TICK, 8'h00, 1'b0, 1'b1);
        key(REQ_KEY,  8'h00, 1'b1, 1'b1);
        key(REQ_KEY,  8'h00, 1'b0, 1'b1);
        key(REQ_KEY,  8'h04, 1'b1, 1'b1);
        key(REQ_KEY,  8'h05, 1'b1, 1'b1);
        key(REQ_KEY,  8'h06, 1'b1, 1'b1);
        key(REQ_KEY,  8'h07, 1'b1, 1'b1);
        key(REQ_KEY,  8'h08, 1'b1, 1'b1);
        key(REQ_KEY,  8'h09, 1'b1, 1'b1);
        key(REQ_KEY,  8'h0A, 1'b1, 1'b1);
        key(REQ_KEY,  8'hE1, 1'b1, 1'b1);
        key(REQ_KEY,  8'h06, 1'b0, 1'b1);
        key(REQ_KEY,  8'hE7, 1'b1, 1'b1);
        key(REQ_KEY,  8'hE1, 1'b0, 1'b1);
        key(REQ_KEY,  8'h0A, 1'b0, 1'b1);
        key(REQ_KEY,  8'hE8, 1'b1, 1'b1);
        key(REQ_KEY,  8'hFF, 1'b1, 1'b1);
        key(REQ_OTHER, 8'hFF, 1'b1, 1'b1);
        key(REQ_RSVD, 8'hFF, 1'b1, 1'b1);
        key(REQ_KEY,  8'hE7, 1'b0, 1'b0);
        key(REQ_TICK, 8'hFF, 1'b1, 1'b1);

        // Random phases across code limits and flow-control mixes;
        // the long back-off runs with a high limit so reports pile up
        run_phase(256, 0, 0, 150, 0);
        run_phase(232, 71, 0, 150, 0);
        run_phase(0, 0, 71, 30, 0);
        run_phase(255, 25, 25, 150, 0);
        run_phase(200 + $urandom_range(56), 0, 0, 150, HOLD_CYCLES);
        run_phase(228, 0, 71, 150, 0);
        settle();

        $display("Covered %0d key events, %0d timer ticks, %0d ignored requests",
                 sb.key_events, sb.ticks, sb.ignored);
        $display("over %0d code limits; checked %0d reports, %0d mismatches",
                 limits_used, sb.reports_seen, sb.mismatches);
        if (sb.mismatches == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
